/* rtl/bsmcu_pkg.sv */
package bsmcu_pkg;

  // Width of one memory word and of each accumulator.
  localparam int WORD_W = 16;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    KIND_LDB    = 3'd0,
    KIND_STB    = 3'd1,
    KIND_BMOVE  = 3'd2,
    KIND_WMOVE  = 3'd3,
    KIND_BCMP   = 3'd4,
    KIND_MWRITE = 3'd5,
    KIND_MREAD  = 3'd6,
    KIND_NOP    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_CAPT,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Which address the current memory access uses.
  typedef enum logic [1:0] {
    ACC_SRC,
    ACC_XLAT,
    ACC_DST,
    ACC_MEM
  } acc_t;

  // Instruction times in nanoseconds.
  localparam logic [13:0] T_LDB_ODD     = 14'd3100;
  localparam logic [13:0] T_LDB_EVEN    = 14'd3700;
  localparam logic [13:0] T_STB_ODD     = 14'd4400;
  localparam logic [13:0] T_STB_EVEN    = 14'd5000;
  localparam logic [13:0] T_BMOVE_EE    = 14'd7900;
  localparam logic [13:0] T_BMOVE_OE    = 14'd6700;
  localparam logic [13:0] T_BMOVE_XO    = 14'd7300;
  localparam logic [13:0] T_XLAT_ODD    = 14'd3100;
  localparam logic [13:0] T_XLAT_EVEN   = 14'd2500;
  localparam logic [13:0] T_WMOVE       = 14'd2700;
  localparam logic [13:0] T_MOVE_ZERO   = 14'd1500;
  localparam logic [13:0] T_BCMP_EE     = 14'd7500;
  localparam logic [13:0] T_BCMP_OE     = 14'd6200;
  localparam logic [13:0] T_BCMP_XO     = 14'd6800;
  localparam logic [13:0] T_BCMP_ZERO   = 14'd1200;
  localparam logic [13:0] T_NONE        = 14'd0;

endpackage

/* rtl/bsmcu_addr.sv */
module bsmcu_addr
  import bsmcu_pkg::*;
#(
  parameter int MEM_WORDS = 32768,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          load,
  input  word_t         addr_in,
  output logic [AW-1:0] addr_out
);

  // Number of conditional subtract steps needed to bring any 16-bit value
  // below MEM_WORDS (restoring reduction, largest multiple first).
  localparam int QBITS = $clog2((65535 / MEM_WORDS) + 1);
  localparam logic [WORD_W:0] MW = (WORD_W+1)'(MEM_WORDS);

  logic [WORD_W:0] rem;
  logic [AW-1:0]   addr_r;

  always_comb begin
    rem = {1'b0, addr_in};
    for (int k = QBITS - 1; k >= 0; k--) begin
      if (rem >= (MW << k)) begin
        rem = rem - (MW << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= rem[AW-1:0];
    end
  end

  assign addr_out = addr_r;

endmodule

/* rtl/byte_string_move_compare_unit.sv */
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_tvalid/in_tready  | in_tuser kind, in_tdata accumulators and memory
// out_    | output    | out_tvalid/out_tready| out_tdata accumulators, repeat, time, read data
//
// One transaction is handled at a time by a small sequencer around a single
// memory port and a shared address reduction register. Each memory access
// loads its address in the address state, then reads and captures the word,
// writes it, or for a byte store or byte move destination does both. Reset is
// synchronous and clears only control state; the memory gets no clearing pass
// and holds unknown data until written. A stalled result holds the block in
// its done state.
module byte_string_move_compare_unit
  import bsmcu_pkg::*;
#(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tuser: kind[2:0]
  input  logic [2:0]  in_tuser,
  // in_tdata: ac0_in[15:0], ac1_in[31:16], ac2_in[47:32], ac3_in[63:48],
  //           mem_addr[78:64], mem_data[94:79], zero fill[95]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: ac0_out[15:0], ac1_out[31:16], ac2_out[47:32], ac3_out[63:48],
  //            repeat_insn[64], time_ns[78:65], read_data[94:79], zero fill[95]
  output logic [95:0] out_tdata
);

  localparam int AW = $clog2(MEM_WORDS);

  // Sequencer state.
  state_t state_r, state_nxt;
  acc_t   acc_r, acc_nxt;

  // Latched instruction and working registers.
  kind_t       kind_r;
  word_t       a0_r, a1_r, a2_r, a3_r;
  logic [14:0] maddr_r;
  word_t       mdata_r;
  word_t       u_r;
  word_t       xa_r;
  logic [13:0] t_r;
  logic        rep_r;
  word_t       rdata_r;

  // Memory port.
  word_t          mem [MEM_WORDS];
  word_t          mem_q_r;
  word_t          mem_wdata;
  logic           mem_re, mem_we;
  logic           addr_load;
  word_t          addr_sel;
  logic [AW-1:0]  mem_addr;

  // Decoded input fields.
  kind_t       in_kind;
  word_t       in_ac0, in_ac1, in_ac2, in_ac3;
  logic [14:0] in_maddr;
  word_t       in_mdata;
  logic        in_work;
  logic [13:0] in_time;
  logic        accept;

  // Capture path helpers.
  logic        cap_sel;
  logic [7:0]  cap_byte;
  word_t       xa_sum;
  word_t       cmp_diff;

  assign in_kind  = kind_t'(in_tuser);
  assign in_ac0   = in_tdata[15:0];
  assign in_ac1   = in_tdata[31:16];
  assign in_ac2   = in_tdata[47:32];
  assign in_ac3   = in_tdata[63:48];
  assign in_maddr = in_tdata[78:64];
  assign in_mdata = in_tdata[94:79];
  assign accept   = in_tvalid && in_tready;

  // An item touches memory unless it is a string instruction with a zero
  // count or the unused kind.
  always_comb begin
    unique case (in_kind)
      KIND_LDB, KIND_STB, KIND_MWRITE, KIND_MREAD: in_work = 1'b1;
      KIND_BMOVE:                                  in_work = (in_ac3 != '0);
      KIND_WMOVE, KIND_BCMP:                       in_work = (in_ac0 != '0);
      default:                                     in_work = 1'b0;
    endcase
  end

  // Base execution time; translation adds its share later.
  always_comb begin
    unique case (in_kind)
      KIND_LDB: in_time = in_ac1[0] ? T_LDB_ODD : T_LDB_EVEN;
      KIND_STB: in_time = in_ac1[0] ? T_STB_ODD : T_STB_EVEN;
      KIND_BMOVE: begin
        if (in_ac3 == '0) begin
          in_time = T_MOVE_ZERO;
        end else if (!in_ac1[0] && !in_ac2[0]) begin
          in_time = T_BMOVE_EE;
        end else if (in_ac1[0] && !in_ac2[0]) begin
          in_time = T_BMOVE_OE;
        end else begin
          in_time = T_BMOVE_XO;
        end
      end
      KIND_WMOVE: in_time = (in_ac0 != '0) ? T_WMOVE : T_MOVE_ZERO;
      KIND_BCMP: begin
        if (in_ac0 == '0) begin
          in_time = T_BCMP_ZERO;
        end else if (!in_ac1[0] && !in_ac2[0]) begin
          in_time = T_BCMP_EE;
        end else if (in_ac1[0] && !in_ac2[0]) begin
          in_time = T_BCMP_OE;
        end else begin
          in_time = T_BCMP_XO;
        end
      end
      default: in_time = T_NONE;
    endcase
  end

  // Byte select of the current access: an odd byte address picks the low half.
  always_comb begin
    unique case (acc_r)
      ACC_SRC:  cap_sel = a1_r[0];
      ACC_XLAT: cap_sel = xa_r[0];
      ACC_DST:  cap_sel = a2_r[0];
      default:  cap_sel = 1'b0;
    endcase
  end

  assign cap_byte = cap_sel ? mem_q_r[7:0] : mem_q_r[15:8];
  assign xa_sum   = a0_r + {8'h00, cap_byte};
  assign cmp_diff = {8'h00, u_r[7:0]} - {8'h00, cap_byte};

  // Address for the reduction unit. Word move and the memory kinds use word
  // addresses; all others use byte addresses shifted down by one.
  always_comb begin
    unique case (acc_r)
      ACC_SRC:  addr_sel = (kind_r == KIND_WMOVE) ? a1_r : {1'b0, a1_r[15:1]};
      ACC_XLAT: addr_sel = {1'b0, xa_r[15:1]};
      ACC_DST:  addr_sel = (kind_r == KIND_WMOVE) ? a2_r : {1'b0, a2_r[15:1]};
      default:  addr_sel = {1'b0, maddr_r};
    endcase
  end

  bsmcu_addr #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_addr (
    .clk      (clk),
    .load     (addr_load),
    .addr_in  (addr_sel),
    .addr_out (mem_addr)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = (in_kind == KIND_MWRITE || in_kind == KIND_MREAD) ? ACC_MEM : ACC_SRC;
          state_nxt = in_work ? ST_ADDR : ST_DONE;
        end
      end
      ST_ADDR: begin
        // Word move destination and memory write need no read first.
        if ((kind_r == KIND_WMOVE && acc_r == ACC_DST) || kind_r == KIND_MWRITE) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CAPT;
      ST_CAPT: begin
        unique case (kind_r)
          KIND_STB: state_nxt = ST_WRITE;
          KIND_BMOVE: begin
            priority case (acc_r)
              ACC_SRC: begin
                acc_nxt   = (a0_r != '0) ? ACC_XLAT : ACC_DST;
                state_nxt = ST_ADDR;
              end
              ACC_XLAT: begin
                acc_nxt   = ACC_DST;
                state_nxt = ST_ADDR;
              end
              default: state_nxt = ST_WRITE;
            endcase
          end
          KIND_WMOVE, KIND_BCMP: begin
            if (acc_r == ACC_SRC) begin
              acc_nxt   = ACC_DST;
              state_nxt = ST_ADDR;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    addr_load  = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready  = 1'b1;
      ST_ADDR:  addr_load  = 1'b1;
      ST_READ:  mem_re     = 1'b1;
      ST_WRITE: mem_we     = 1'b1;
      ST_DONE:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= ACC_SRC;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Write data: byte writes merge into the word just read.
  always_comb begin
    unique case (kind_r)
      KIND_STB:   mem_wdata = a1_r[0] ? {mem_q_r[15:8], a0_r[7:0]}
                                      : {a0_r[7:0], mem_q_r[7:0]};
      KIND_BMOVE: mem_wdata = a2_r[0] ? {mem_q_r[15:8], u_r[7:0]}
                                      : {u_r[7:0], mem_q_r[7:0]};
      KIND_WMOVE: mem_wdata = u_r;
      default:    mem_wdata = mdata_r;
    endcase
  end

  // Word memory with a single port and registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      a0_r    <= in_ac0;
      a1_r    <= in_ac1;
      a2_r    <= in_ac2;
      a3_r    <= in_ac3;
      maddr_r <= in_maddr;
      mdata_r <= in_mdata;
      t_r     <= in_time;
      rep_r   <= 1'b0;
      rdata_r <= '0;
    end else if (state_r == ST_CAPT) begin
      unique case (kind_r)
        KIND_LDB: a0_r <= {8'h00, cap_byte};
        KIND_BMOVE: begin
          // The destination read only supplies the other half of the word.
          if (acc_r != ACC_DST) begin
            u_r <= {8'h00, cap_byte};
          end
          if (acc_r == ACC_SRC && a0_r != '0) begin
            xa_r <= xa_sum;
            t_r  <= t_r + (xa_sum[0] ? T_XLAT_ODD : T_XLAT_EVEN);
          end
        end
        KIND_WMOVE: u_r <= mem_q_r;
        KIND_BCMP: begin
          if (acc_r == ACC_SRC) begin
            u_r <= {8'h00, cap_byte};
          end else begin
            // Second byte in hand: advance both addresses and settle ac0.
            a1_r <= a1_r + 16'd1;
            a2_r <= a2_r + 16'd1;
            if (u_r[7:0] != cap_byte) begin
              a0_r <= cmp_diff;
            end else begin
              a0_r  <= a0_r - 16'd1;
              rep_r <= 1'b1;
            end
          end
        end
        KIND_MREAD: rdata_r <= mem_q_r;
        default: ;
      endcase
    end else if (state_r == ST_WRITE) begin
      unique case (kind_r)
        KIND_BMOVE: begin
          a1_r  <= a1_r + 16'd1;
          a2_r  <= a2_r + 16'd1;
          a3_r  <= a3_r - 16'd1;
          rep_r <= 1'b1;
        end
        KIND_WMOVE: begin
          a1_r  <= a1_r + 16'd1;
          a2_r  <= a2_r + 16'd1;
          a0_r  <= a0_r - 16'd1;
          rep_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tdata = {1'b0, rdata_r, t_r, rep_r, a3_r, a2_r, a1_r, a0_r};

`ifndef SYNTHESIS
  // Only one transaction is ever in flight.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input accepted while a result is pending");

  // Accepting an item always leaves the idle state.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_tready)
    else $error("still ready the cycle after an accepted item");

  // The single memory port never reads and writes in one cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_re && mem_we))
    else $error("memory read and write in the same cycle");

  // Only the string instructions ask for re-execution.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rep_r) |->
      (kind_r == KIND_BMOVE || kind_r == KIND_WMOVE || kind_r == KIND_BCMP))
    else $error("repeat flagged for a kind that never repeats");
`endif

endmodule

/* verif/tb_byte_string_move_compare_unit.sv */
`timescale 1ns / 1ps

module tb_byte_string_move_compare_unit
  import bsmcu_pkg::*;
();

  // The memory size matches the block's default so that addresses wrap the same way.
  localparam int MEM_WORDS = 32768;

  // Memory is unknown until written, so every instruction that reads or
  // read-modify-writes memory works inside a few regions, or on a word that
  // a memory write set first. Each region is filled by memory write
  // transactions before anything reads it. A region holds a whole translation
  // table (256 bytes from any of its first 128 bytes) with room to spare.
  localparam int NUM_REGIONS  = 3;
  localparam int REGION_WORDS = 192;
  localparam int REGION_BYTES = 2 * REGION_WORDS;

  localparam int RANDOM_INSNS = 1200;

  // The slowest correct gap between two accepted transactions is a sender
  // gap, a translated byte move and a receiver stall in a row. The limit
  // leaves a wide margin above that.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;

  // One step of a string instruction, or a direct memory access.
  typedef struct {
    kind_t       kind;
    word_t       ac0;
    word_t       ac1;
    word_t       ac2;
    word_t       ac3;
    logic [14:0] mem_addr;
    word_t       mem_data;
  } string_insn_t;

  // What the block returns for one step.
  typedef struct {
    word_t       ac0;
    word_t       ac1;
    word_t       ac2;
    word_t       ac3;
    logic        repeat_insn;
    logic [13:0] time_ns;
    word_t       read_data;
  } insn_result_t;

  // The scoreboard keeps its own image of the word memory and executes each
  // accepted instruction step on it. The expected results wait in order for
  // the result channel.
  class string_unit_scoreboard;
    word_t        mem_image [MEM_WORDS];
    insn_result_t expected_results [$];
    insn_result_t last_result;
    int           error_count;

    function new();
      error_count = 0;
      foreach (mem_image[i]) mem_image[i] = '0;
    endfunction

    function word_t read_byte(word_t ba);
      word_t w;
      w = mem_image[(ba >> 1) % MEM_WORDS];
      return ba[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
    endfunction

    function void write_byte(word_t ba, word_t d);
      int unsigned wa;
      wa = (ba >> 1) % MEM_WORDS;
      if (ba[0]) begin
        mem_image[wa][7:0] = d[7:0];
      end else begin
        mem_image[wa][15:8] = d[7:0];
      end
    endfunction

    function insn_result_t execute_step(string_insn_t it);
      insn_result_t r;
      word_t        u;
      word_t        v;
      word_t        ta;
      logic [13:0]  t;
      r.ac0         = it.ac0;
      r.ac1         = it.ac1;
      r.ac2         = it.ac2;
      r.ac3         = it.ac3;
      r.repeat_insn = 1'b0;
      r.read_data   = '0;
      t             = T_NONE;
      case (it.kind)
        KIND_LDB: begin
          r.ac0 = read_byte(it.ac1);
          t     = it.ac1[0] ? T_LDB_ODD : T_LDB_EVEN;
        end
        KIND_STB: begin
          write_byte(it.ac1, it.ac0);
          t = it.ac1[0] ? T_STB_ODD : T_STB_EVEN;
        end
        KIND_BMOVE: begin
          if (it.ac3 != 0) begin
            if (!it.ac1[0] && !it.ac2[0]) t = T_BMOVE_EE;
            else if (it.ac1[0] && !it.ac2[0]) t = T_BMOVE_OE;
            else t = T_BMOVE_XO;
            u = read_byte(it.ac1);
            // A nonzero ac0 is the byte address of a translation table.
            if (it.ac0 != 0) begin
              ta = it.ac0 + u;
              t  = t + (ta[0] ? T_XLAT_ODD : T_XLAT_EVEN);
              u  = read_byte(ta);
            end
            write_byte(it.ac2, u);
            r.ac1         = it.ac1 + 16'd1;
            r.ac2         = it.ac2 + 16'd1;
            r.ac3         = it.ac3 - 16'd1;
            r.repeat_insn = 1'b1;
          end else begin
            t = T_MOVE_ZERO;
          end
        end
        KIND_WMOVE: begin
          if (it.ac0 != 0) begin
            t = T_WMOVE;
            mem_image[it.ac2 % MEM_WORDS] = mem_image[it.ac1 % MEM_WORDS];
            r.ac1         = it.ac1 + 16'd1;
            r.ac2         = it.ac2 + 16'd1;
            r.ac0         = it.ac0 - 16'd1;
            r.repeat_insn = 1'b1;
          end else begin
            t = T_MOVE_ZERO;
          end
        end
        KIND_BCMP: begin
          if (it.ac0 != 0) begin
            if (!it.ac1[0] && !it.ac2[0]) t = T_BCMP_EE;
            else if (it.ac1[0] && !it.ac2[0]) t = T_BCMP_OE;
            else t = T_BCMP_XO;
            u     = read_byte(it.ac1);
            v     = read_byte(it.ac2);
            r.ac1 = it.ac1 + 16'd1;
            r.ac2 = it.ac2 + 16'd1;
            // A mismatch ends the compare with the byte difference in ac0.
            if (u != v) begin
              r.ac0 = u - v;
            end else begin
              r.ac0         = it.ac0 - 16'd1;
              r.repeat_insn = 1'b1;
            end
          end else begin
            t = T_BCMP_ZERO;
          end
        end
        KIND_MWRITE: mem_image[it.mem_addr % MEM_WORDS] = it.mem_data;
        KIND_MREAD:  r.read_data = mem_image[it.mem_addr % MEM_WORDS];
        default: ;
      endcase
      r.time_ns = t;
      return r;
    endfunction

    function void note_insn(string_insn_t it);
      last_result = execute_step(it);
      expected_results.push_back(last_result);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_result(logic [95:0] d);
      insn_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transaction with no instruction pending: %h", d);
        error_count++;
        return;
      end
      e = expected_results.pop_front();
      check_field("ac0_out", 32'(e.ac0), 32'(d[15:0]));
      check_field("ac1_out", 32'(e.ac1), 32'(d[31:16]));
      check_field("ac2_out", 32'(e.ac2), 32'(d[47:32]));
      check_field("ac3_out", 32'(e.ac3), 32'(d[63:48]));
      check_field("repeat_insn", 32'(e.repeat_insn), 32'(d[64]));
      check_field("time_ns", 32'(e.time_ns), 32'(d[78:65]));
      check_field("read_data", 32'(e.read_data), 32'(d[94:79]));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = '0;
  logic [95:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  string_unit_scoreboard results_board;

  // Counts of accepted input transactions and the quiet stretches of each side.
  int          insns_sent = 0;
  int          in_calm    = 0;
  int          out_calm   = 0;
  int          idle_cycles = 0;

  // Word address where each region starts, and words written at random addresses.
  int unsigned region_base [NUM_REGIONS];
  logic [14:0] extra_words [$];

  byte_string_move_compare_unit #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // The watchdog ends the run when neither channel has moved a transaction
  // for far longer than any correct instruction can take.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_string_move_compare_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Each side waits at random before each transaction. Now and then a side
  // enters a quiet stretch in which it does not wait at all, so that
  // back-to-back transactions are covered as well.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  function automatic word_t region_byte(int r, int off);
    return word_t'(region_base[r] * 2 + off);
  endfunction

  function automatic logic [14:0] region_word(int r, int off);
    return 15'((region_base[r] + off) % MEM_WORDS);
  endfunction

  function automatic string_insn_t make_insn(kind_t k, word_t a0, word_t a1, word_t a2,
                                             word_t a3, logic [14:0] ma, word_t md);
    string_insn_t it;
    it.kind     = k;
    it.ac0      = a0;
    it.ac1      = a1;
    it.ac2      = a2;
    it.ac3      = a3;
    it.mem_addr = ma;
    it.mem_data = md;
    return it;
  endfunction

  // Drive one instruction step and return at the edge where the block takes
  // it. The valid line stays high when the next transaction follows at once,
  // so it never gets two assignments in one time step.
  task automatic send_insn(string_insn_t it);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {1'b0, it.mem_data, it.mem_addr, it.ac3, it.ac2, it.ac1, it.ac0};
    do @(posedge clk); while (!in_tready);
    results_board.note_insn(it);
    insns_sent++;
  endtask

  // A repeating instruction is re-executed the way a processor would: the
  // updated accumulators of one step go back in as the next step. The chain
  // stops when no repeat is requested or after max_steps, which leaves an
  // instruction unfinished on purpose.
  task automatic run_chain(string_insn_t first, int max_steps);
    string_insn_t it;
    int           steps;
    it = first;
    send_insn(it);
    steps = 1;
    while (results_board.last_result.repeat_insn && steps < max_steps) begin
      it.ac0      = results_board.last_result.ac0;
      it.ac1      = results_board.last_result.ac1;
      it.ac2      = results_board.last_result.ac2;
      it.ac3      = results_board.last_result.ac3;
      it.mem_addr = 15'($urandom);
      it.mem_data = word_t'($urandom);
      send_insn(it);
      steps++;
    end
  endtask

  // The result side: stall at random, then take one result transaction and
  // check it against the oldest expectation.
  task automatic collect_results();
    int stall;
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_board.check_result(out_tdata);
    end
  endtask

  initial begin : stimulus
    int    random_start;
    int    pick;
    int    n;
    int    rs;
    int    rd;
    int    steps;
    word_t src;
    word_t dst;
    word_t xlat;

    results_board = new();

    // Region 0 straddles the top of memory, so moves through it wrap both
    // the word addresses and the 16-bit byte addresses.
    region_base[0] = MEM_WORDS - 64;
    for (int r = 1; r < NUM_REGIONS; r++) region_base[r] = $urandom_range(0, MEM_WORDS - 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    fork
      collect_results();
    join_none

    // Fill every region with random words before anything reads them.
    for (int r = 0; r < NUM_REGIONS; r++) begin
      for (int w = 0; w < REGION_WORDS; w++) begin
        send_insn(make_insn(KIND_MWRITE, word_t'($urandom), word_t'($urandom),
                            word_t'($urandom), word_t'($urandom), region_word(r, w),
                            word_t'($urandom)));
      end
    end

    // Directed steps. The top word of memory, byte loads of both halves,
    // byte stores of both halves, and the three zero-count cases.
    send_insn(make_insn(KIND_MWRITE, '0, '0, '0, '0, 15'h7fff, 16'hffff));
    send_insn(make_insn(KIND_MREAD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff, '0));
    send_insn(make_insn(KIND_LDB, '0, 16'hffff, '0, '0, '0, '0));
    send_insn(make_insn(KIND_LDB, '0, 16'hfffe, '0, '0, '0, '0));
    send_insn(make_insn(KIND_STB, 16'hffff, 16'h0001, '0, '0, '0, '0));
    send_insn(make_insn(KIND_STB, 16'h0000, 16'h0000, '0, '0, '0, '0));
    send_insn(make_insn(KIND_MREAD, '0, '0, '0, '0, 15'h0000, '0));
    send_insn(make_insn(KIND_BMOVE, 16'hffff, 16'hffff, 16'hffff, 16'h0000, '0, '0));
    send_insn(make_insn(KIND_WMOVE, 16'h0000, 16'hffff, 16'hffff, 16'hffff, '0, '0));
    send_insn(make_insn(KIND_BCMP, 16'h0000, 16'hffff, 16'hffff, 16'hffff, '0, '0));

    // One byte move step for each parity pairing of source and destination.
    send_insn(make_insn(KIND_BMOVE, '0, 16'h0010, 16'h0020, 16'h0001, '0, '0));
    send_insn(make_insn(KIND_BMOVE, '0, 16'h0011, 16'h0020, 16'h0001, '0, '0));
    send_insn(make_insn(KIND_BMOVE, '0, 16'h0010, 16'h0021, 16'h0001, '0, '0));
    send_insn(make_insn(KIND_BMOVE, '0, 16'h0011, 16'h0021, 16'h0001, '0, '0));

    // Translated moves with an even and an odd table entry. The table sits
    // at the start of region 0, at byte 0xff80 near the top of byte addresses.
    send_insn(make_insn(KIND_STB, 16'h0000, 16'h0030, '0, '0, '0, '0));
    send_insn(make_insn(KIND_STB, 16'h0001, 16'h0031, '0, '0, '0, '0));
    send_insn(make_insn(KIND_BMOVE, 16'hff80, 16'h0030, 16'h0040, 16'h0001, '0, '0));
    send_insn(make_insn(KIND_BMOVE, 16'hff80, 16'h0031, 16'h0041, 16'h0001, '0, '0));

    // A word move that wraps from the last word to word 0, run to its end.
    run_chain(make_insn(KIND_WMOVE, 16'h0002, 16'hffff, 16'h0040, 16'h1234, '0, '0), 1000);

    // A compare of a string with itself counts down to zero.
    run_chain(make_insn(KIND_BCMP, 16'h0003, 16'h0050, 16'h0050, '0, '0, '0), 1000);

    // A compare that fails on its first byte, 0x00 against 0xff.
    send_insn(make_insn(KIND_STB, 16'h0000, 16'h0060, '0, '0, '0, '0));
    send_insn(make_insn(KIND_STB, 16'h00ff, 16'h0061, '0, '0, '0, '0));
    send_insn(make_insn(KIND_BCMP, 16'h0001, 16'h0060, 16'h0061, '0, '0, '0));

    // The unused kind with every other bit set.
    send_insn(make_insn(KIND_NOP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff, 16'hffff));

    // Random part. Most of it is whole instructions run to completion with
    // random data; the rest is single steps, abandoned instructions and
    // transactions that touch no memory at all.
    random_start = insns_sent;
    while (insns_sent - random_start < RANDOM_INSNS) begin
      pick = $urandom_range(0, 99);
      n    = $urandom_range(1, 24);
      rs   = $urandom_range(0, NUM_REGIONS - 1);
      rd   = $urandom_range(0, NUM_REGIONS - 1);
      src  = region_byte(rs, $urandom_range(0, REGION_BYTES - n));
      dst  = region_byte(rd, $urandom_range(0, REGION_BYTES - n));
      steps = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : 1000;
      if (pick < 30) begin
        // Byte move, translated through a table in about half of the cases.
        xlat = '0;
        if ($urandom_range(0, 1) == 1) begin
          xlat = region_byte($urandom_range(0, NUM_REGIONS - 1), $urandom_range(0, 127));
        end
        run_chain(make_insn(KIND_BMOVE, xlat, src, dst, word_t'(n), 15'($urandom),
                            word_t'($urandom)), steps);
      end else if (pick < 45) begin
        // Word move. Bit 15 of a word address is ignored by the wrap, so it
        // is set at random.
        n = $urandom_range(1, 16);
        run_chain(make_insn(KIND_WMOVE, word_t'(n),
                            {1'($urandom), region_word(rs, $urandom_range(0, REGION_WORDS - n))},
                            {1'($urandom), region_word(rd, $urandom_range(0, REGION_WORDS - n))},
                            word_t'($urandom), 15'($urandom), word_t'($urandom)), steps);
      end else if (pick < 60) begin
        // Copy a string, perhaps spoil one byte of the copy, then compare.
        run_chain(make_insn(KIND_BMOVE, '0, src, dst, word_t'(n), 15'($urandom),
                            word_t'($urandom)), 1000);
        if ($urandom_range(0, 1) == 1) begin
          send_insn(make_insn(KIND_STB, word_t'($urandom), dst + word_t'($urandom_range(0, n - 1)),
                              word_t'($urandom), word_t'($urandom), 15'($urandom),
                              word_t'($urandom)));
        end
        run_chain(make_insn(KIND_BCMP, word_t'(n), src, dst, word_t'($urandom), 15'($urandom),
                            word_t'($urandom)), 1000);
      end else if (pick < 67) begin
        run_chain(make_insn(KIND_BCMP, word_t'(n), src, dst, word_t'($urandom), 15'($urandom),
                            word_t'($urandom)), steps);
      end else if (pick < 75) begin
        send_insn(make_insn(KIND_LDB, word_t'($urandom),
                            region_byte(rs, $urandom_range(0, REGION_BYTES - 1)),
                            word_t'($urandom), word_t'($urandom), 15'($urandom),
                            word_t'($urandom)));
      end else if (pick < 82) begin
        send_insn(make_insn(KIND_STB, word_t'($urandom),
                            region_byte(rs, $urandom_range(0, REGION_BYTES - 1)),
                            word_t'($urandom), word_t'($urandom), 15'($urandom),
                            word_t'($urandom)));
      end else if (pick < 88) begin
        // Memory write anywhere; words written at random addresses are remembered
        // so that they can be read back later.
        if ($urandom_range(0, 9) < 4) begin
          extra_words.push_back(15'($urandom));
          send_insn(make_insn(KIND_MWRITE, word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom), extra_words[$],
                              word_t'($urandom)));
        end else begin
          send_insn(make_insn(KIND_MWRITE, word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom),
                              region_word(rs, $urandom_range(0, REGION_WORDS - 1)),
                              word_t'($urandom)));
        end
      end else if (pick < 94) begin
        if (extra_words.size() != 0 && $urandom_range(0, 1) == 1) begin
          send_insn(make_insn(KIND_MREAD, word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom),
                              extra_words[$urandom_range(0, extra_words.size() - 1)],
                              word_t'($urandom)));
        end else begin
          send_insn(make_insn(KIND_MREAD, word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom),
                              region_word(rs, $urandom_range(0, REGION_WORDS - 1)),
                              word_t'($urandom)));
        end
      end else if (pick < 97) begin
        // Zero counts touch no memory, so every other field is random.
        case ($urandom_range(0, 2))
          0: send_insn(make_insn(KIND_BMOVE, word_t'($urandom), word_t'($urandom),
                                 word_t'($urandom), '0, 15'($urandom), word_t'($urandom)));
          1: send_insn(make_insn(KIND_WMOVE, '0, word_t'($urandom), word_t'($urandom),
                                 word_t'($urandom), 15'($urandom), word_t'($urandom)));
          default: send_insn(make_insn(KIND_BCMP, '0, word_t'($urandom), word_t'($urandom),
                                       word_t'($urandom), 15'($urandom), word_t'($urandom)));
        endcase
      end else begin
        send_insn(make_insn(KIND_NOP, word_t'($urandom), word_t'($urandom), word_t'($urandom),
                            word_t'($urandom), 15'($urandom), word_t'($urandom)));
      end
    end
    in_tvalid <= 1'b0;

    // Let every result arrive, then watch a little longer for stray ones.
    while (results_board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results_board.error_count == 0 && results_board.expected_results.size() == 0) begin
      $display("byte_string_move_compare_unit regression: pass");
    end else begin
      $display("byte_string_move_compare_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bsmcu_pkg.sv
rtl/bsmcu_addr.sv
rtl/byte_string_move_compare_unit.sv
verif/tb_byte_string_move_compare_unit.sv
